// ----- hw/rtl/dmbc_pkg.sv -----
// Shared constants for the distinct address bitmap counter.
// No dependencies; imported by the core and its RAM.
package dmbc_pkg;

	localparam int ID_BITS_DEF     = 16;
	localparam int WORD_BITS_DEF   = 32;
	localparam int MAC_W           = 48;
	localparam int RSSI_W          = 8;
	localparam int STATUS_W        = 3;
	localparam int COUNT_W         = 17;
	localparam int LOCAL_ADMIN_BIT = 41;

	localparam logic [STATUS_W-1:0] ST_WEAK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_GLOBAL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SEEN    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

endpackage

// ----- hw/rtl/dmbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on dmbc_pkg for the default WIDTH; no reset on storage.
module dmbc_ram #(
	parameter int WIDTH = dmbc_pkg::WORD_BITS_DEF,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import dmbc_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/distinct_mac_bitmap_counter_core.sv -----
// Distinct randomized-address counter: seen-bitmap in one RAM, read-modify-write.
// Depends on dmbc_pkg and dmbc_ram.
//
// Input channel (in_valid/in_ready) carries opcode, mac_address and rssi; every
// input beat yields exactly one output beat (status, distinct_count) on the
// out_valid/out_ready channel, held in an output register.
// Observe: the RAM word is read at accept, then tested and written back in
// S_MAP, where the result is registered; S_MAP waits while the output register
// is full. in_ready is low in S_MAP, so a new beat is taken only after the last
// result is registered. Items are handled one at a time.
// Clear: the 2^ID_BITS/WORD_BITS bitmap words (2048 by default) are wiped one per cycle,
// then S_FIN posts the result once the output register is free; in_ready is low meanwhile.
// Reset: control state clears at once and the same wipe runs over all RAM words
// with no result; in_ready stays low until it ends.
// The threshold register resets to -128 and can be written any time via
// cfg_we/cfg_wdata.
// Stall: if the output register is still full when a result is ready, the
// core holds that result internally and keeps in_ready low until it drains.
module distinct_mac_bitmap_counter_core #(
	parameter int ID_BITS   = dmbc_pkg::ID_BITS_DEF,
	parameter int WORD_BITS = dmbc_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 opcode,
	input  logic [dmbc_pkg::MAC_W-1:0]           mac_address,
	input  logic signed [dmbc_pkg::RSSI_W-1:0]   rssi,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dmbc_pkg::STATUS_W-1:0]        status,
	output logic [dmbc_pkg::COUNT_W-1:0]         distinct_count,
	input  logic                                 cfg_we,
	input  logic signed [dmbc_pkg::RSSI_W-1:0]   cfg_wdata
);
	import dmbc_pkg::*;

	localparam int MAP_WORDS = ((1 << ID_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int RK        = ID_BITS + 7;
	localparam int PW        = ID_BITS + RK;
	localparam logic [PW-1:0] RECIP = PW'(((64'd1 << RK) + WORD_BITS - 1) / WORD_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAP  = 2'd1;
	localparam logic [1:0] S_WIPE = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]              state_q;
	logic [AW-1:0]           ptr_q;
	logic                    pend_q;
	logic signed [RSSI_W-1:0] thr_q;
	logic [ID_BITS:0]        total_q;

	logic                    do_map_s1;
	logic [STATUS_W-1:0]     status_s1;
	logic [ID_BITS-1:0]      id_s1;
	logic [AW-1:0]           word_s1;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [COUNT_W-1:0]      count_q;

	logic                    in_acc;
	logic [ID_BITS-1:0]      id_in;
	logic [PW-1:0]           prod;
	logic [AW-1:0]           word_in;
	logic [ID_BITS-1:0]      word_base;
	logic [BW-1:0]           bit_sel;
	logic [WORD_BITS-1:0]    rdata;
	logic [WORD_BITS-1:0]    bit_mask;
	logic                    hit;
	logic                    out_free;
	logic                    map_done;
	logic                    res_post;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [WORD_BITS-1:0]    ram_wdata;
	logic [STATUS_W-1:0]     map_status;
	logic [ID_BITS:0]        map_total;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// word index = id / WORD_BITS by reciprocal multiply (exact over the id range)
	assign id_in   = mac_address[ID_BITS-1:0];
	assign prod    = PW'(id_in) * RECIP;
	assign word_in = AW'(prod >> RK);

	assign word_base = ID_BITS'(ID_BITS'(word_s1) * ID_BITS'(WORD_BITS));
	assign bit_sel   = BW'(id_s1 - word_base);
	assign bit_mask  = WORD_BITS'(1) << bit_sel;
	assign hit       = |(rdata & bit_mask);

	assign map_done   = (state_q == S_MAP) && out_free;
	assign res_post   = ((state_q == S_MAP) || (state_q == S_FIN)) && out_free;
	assign map_status = !do_map_s1 ? status_s1 : (hit ? ST_SEEN : ST_NEW);
	assign map_total  = (do_map_s1 && !hit) ? total_q + 1'b1 : total_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (state_q == S_WIPE) begin
			ram_we = 1'b1;
		end else if (map_done && do_map_s1 && !hit) begin
			ram_we    = 1'b1;
			ram_waddr = word_s1;
			ram_wdata = rdata | bit_mask;
		end
	end

	dmbc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS),
		.AW   (AW)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(word_in),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= -8'sd128;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_s1   <= id_in;
			word_s1 <= word_in;
			if (opcode == OP_CLEAR) begin
				do_map_s1 <= 1'b0;
				status_s1 <= ST_CLEARED;
			end else if (rssi < thr_q) begin
				do_map_s1 <= 1'b0;
				status_s1 <= ST_WEAK;
			end else if (!mac_address[LOCAL_ADMIN_BIT]) begin
				do_map_s1 <= 1'b0;
				status_s1 <= ST_GLOBAL;
			end else begin
				do_map_s1 <= 1'b1;
				status_s1 <= ST_NEW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_WEAK;
			count_q     <= '0;
		end else begin
			if (res_post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (opcode == OP_CLEAR) begin
							state_q <= S_WIPE;
							ptr_q   <= '0;
							pend_q  <= 1'b1;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					if (out_free) begin
						total_q     <= map_total;
						status_q    <= map_status;
						count_q     <= COUNT_W'(map_total);
						state_q     <= S_IDLE;
					end
				end
				S_WIPE: begin
					total_q <= '0;
					ptr_q   <= ptr_q + 1'b1;
					if (ptr_q == LAST_WORD) begin
						state_q <= pend_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						status_q    <= ST_CLEARED;
						count_q     <= '0;
						pend_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign distinct_count = count_q;

endmodule

// ----- dv/tb_top.sv -----
// Testbench for distinct_mac_bitmap_counter_core: directed and random observe/clear beats.
// Results are checked against an in-bench bitmap tally and threshold model.
// Depends on dmbc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
	import dmbc_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} tally_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     opcode;
	logic [MAC_W-1:0]         mac_address;
	logic signed [RSSI_W-1:0] rssi;
	logic                     out_valid;
	logic                     out_ready;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       distinct_count;
	logic                     cfg_we;
	logic signed [RSSI_W-1:0] cfg_wdata;

	// bench copy of the core state
	bit                       seen_ids [0:(1 << ID_BITS_DEF) - 1];
	logic [COUNT_W-1:0]       tally_total;
	logic signed [RSSI_W-1:0] rssi_floor;

	tally_t pending_tallies[$];
	int     err_count;
	int     send_idle_pct;
	int     recv_stall_pct;

	distinct_mac_bitmap_counter_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.mac_address    (mac_address),
		.rssi           (rssi),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.distinct_count (distinct_count),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void wipe_tally();
		foreach (seen_ids[i])
			seen_ids[i] = 1'b0;
		tally_total = '0;
	endfunction

	function automatic tally_t tally_address(input logic op, input logic [MAC_W-1:0] mac,
	                                         input logic signed [RSSI_W-1:0] r);
		tally_t res;
		int     id;
		if (op == OP_CLEAR) begin
			wipe_tally();
			res.status = ST_CLEARED;
		end else if (r < rssi_floor) begin
			res.status = ST_WEAK;
		end else if (!mac[LOCAL_ADMIN_BIT]) begin
			res.status = ST_GLOBAL;
		end else begin
			id = int'(mac[ID_BITS_DEF-1:0]);
			if (seen_ids[id]) begin
				res.status = ST_SEEN;
			end else begin
				seen_ids[id] = 1'b1;
				tally_total++;
				res.status = ST_NEW;
			end
		end
		res.count = tally_total;
		return res;
	endfunction

	// result side: check every accepted beat, then pick next stall
	initial begin
		tally_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_tallies.size() == 0) begin
					report_mismatch($sformatf("unexpected beat status=%0d count=%0d",
						status, distinct_count));
				end else begin
					want = pending_tallies.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want.status));
					if (distinct_count !== want.count)
						report_mismatch($sformatf("count got %0d want %0d",
							distinct_count, want.count));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_beat(input logic op, input logic [MAC_W-1:0] mac,
	                         input logic signed [RSSI_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		mac_address <= mac;
		rssi        <= r;
		do
			@(posedge clk);
		while (!in_ready);
		pending_tallies.push_back(tally_address(op, mac, r));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_floor(input logic signed [RSSI_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		rssi_floor = v;
	endtask

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [MAC_W-1:0] m;
		m[MAC_W-1:16] = $urandom;
		if ($urandom_range(99) < 70)
			m[15:0] = 16'($urandom_range(300));
		else
			m[15:0] = 16'($urandom);
		m[LOCAL_ADMIN_BIT] = ($urandom_range(99) < 85);
		return m;
	endfunction

	function automatic logic signed [RSSI_W-1:0] rand_rssi();
		int lo;
		lo = int'(rssi_floor);
		if ($urandom_range(99) < 80)
			return RSSI_W'($urandom_range(127 - lo) + lo);
		return RSSI_W'($urandom);
	endfunction

	task automatic test_directed();
		set_floor(-8'sd128);
		send_beat(OP_OBSERVE, 48'h02_00_00_00_00_05, -8'sd128);
		send_beat(OP_OBSERVE, 48'h02_00_00_00_00_05, 8'sd10);
		send_beat(OP_OBSERVE, 48'h0, 8'sd127);
		send_beat(OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 8'sd127);
		send_beat(OP_OBSERVE, 48'hFDFF_FFFF_FFFF, 8'sd0);
		send_beat(OP_OBSERVE, 48'h0200_0000_FFFF, -8'sd1);
		send_beat(OP_CLEAR, 48'hFFFF_FFFF_FFFF, -8'sd1);
		send_beat(OP_OBSERVE, 48'h02_00_00_00_00_05, 8'sd0);
		set_floor(8'sd127);
		send_beat(OP_OBSERVE, 48'h0, 8'sd126);
		send_beat(OP_OBSERVE, 48'h0200_0000_0000, 8'sd127);
		send_beat(OP_OBSERVE, 48'h0200_0000_0001, -8'sd128);
		set_floor(-8'sd20);
		send_beat(OP_OBSERVE, 48'h0200_0000_0000, -8'sd21);
		send_beat(OP_OBSERVE, 48'h0200_0000_0000, -8'sd20);
		send_beat(OP_OBSERVE, 48'h0200_0000_1234, 8'sd0);
		send_beat(OP_OBSERVE, 48'h0200_0000_1235, 8'sd0);
		send_beat(OP_CLEAR, 48'h0, 8'sd0);
		send_beat(OP_OBSERVE, 48'h0200_0000_1234, 8'sd0);
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n,
	                                 input logic signed [RSSI_W-1:0] floor_v);
		set_floor(floor_v);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) begin
			if ($urandom_range(999) < 4)
				send_beat(OP_CLEAR, rand_mac(), RSSI_W'($urandom));
			else
				send_beat(OP_OBSERVE, rand_mac(), rand_rssi());
		end
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		opcode         <= OP_OBSERVE;
		mac_address    <= '0;
		rssi           <= '0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		err_count      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rssi_floor     = -8'sd128;
		wipe_tally();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(0, 0, 345, -8'sd128);
		test_random_phase(78, 0, 345, -8'sd40);
		test_random_phase(0, 78, 345, RSSI_W'($urandom));
		test_random_phase(14, 14, 345, 8'sd127);
		test_random_phase(0, 0, 40, 8'sd0);

		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
